/* sv/svpwm_pkg.sv */
package svpwm_pkg;

   localparam int unsigned REG_WIDTH = 8;
   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam int unsigned ANGLE_WIDTH = 2;
   localparam int unsigned POWER_WIDTH = 4;

   localparam logic [ANGLE_WIDTH-1:0] ANGLE_ONE = 2'd1;
   localparam logic [ANGLE_WIDTH-1:0] ANGLE_TWO = 2'd2;
   localparam logic [ANGLE_WIDTH-1:0] ANGLE_THREE = 2'd3;

   localparam logic [POWER_WIDTH-1:0] POWER_RESET = 4'd5;

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_ANGLE1_HIGH = 3'd0,
      CSR_ANGLE2_HIGH = 3'd1,
      CSR_ANGLE3_HIGH = 3'd2,
      CSR_SERVO_LOW   = 3'd3,
      CSR_PWM_SLOT    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [REG_WIDTH-1:0] angle1_high_ticks;
      logic [REG_WIDTH-1:0] angle2_high_ticks;
      logic [REG_WIDTH-1:0] angle3_high_ticks;
      logic [REG_WIDTH-1:0] servo_low_ticks;
      logic [REG_WIDTH-1:0] pwm_slot_ticks;
   } cfg_type;

   typedef struct packed {
      logic tick;
      logic press_direction;
      logic press_power;
      logic press_angle;
   } item_type;

   typedef struct packed {
      logic                   servo_pulse;
      logic                   drive_forward;
      logic                   drive_reverse;
      logic [ANGLE_WIDTH-1:0] angle_select;
      logic [POWER_WIDTH-1:0] power_level;
   } result_type;

   function automatic logic [REG_WIDTH-1:0] at_least_one(input logic [REG_WIDTH-1:0] v);
      return (v == '0) ? REG_WIDTH'(1) : v;
   endfunction

endpackage

/* sv/svpwm_req_if.sv */
interface svpwm_req_if;
   logic valid;
   logic ready;
   logic tick;
   logic press_direction;
   logic press_power;
   logic press_angle;

   modport source (output valid, tick, press_direction, press_power, press_angle,
                   input ready);
   modport sink (input valid, tick, press_direction, press_power, press_angle,
                 output ready);
endinterface

/* sv/svpwm_rsp_if.sv */
interface svpwm_rsp_if;
   logic       valid;
   logic       ready;
   logic       servo_pulse;
   logic       drive_forward;
   logic       drive_reverse;
   logic [1:0] angle_select;
   logic [3:0] power_level;

   modport source (output valid, servo_pulse, drive_forward, drive_reverse, angle_select,
                   power_level, input ready);
   modport sink (input valid, servo_pulse, drive_forward, drive_reverse, angle_select,
                 power_level, output ready);
endinterface

/* sv/servo_and_dc_motor_pwm_drive_top.sv */
// Channel   Direction  Handshake        Payload
// req_chan  in         valid / ready    tick, press_direction, press_power, press_angle
// rsp_chan  out        valid / ready    servo_pulse, drive_forward, drive_reverse,
//                                       angle_select, power_level
// csr_*     in         csr_we           csr_addr, csr_wdata
//
// One item is taken per clock cycle unless the output stalls; each item yields one
// result, which passes through an input register and then a result register.
// The reset is synchronous and active high; no item is accepted while it is asserted.
// A stalled result holds in the result register while the next item waits in the input
// register, so the input side stops only when both registers are full.
module servo_and_dc_motor_pwm_drive_top
   import svpwm_pkg::*;
#(
   parameter int unsigned PWM_SLOTS = 10
)
(
   input  logic                      clock,
   input  logic                      reset,
   svpwm_req_if.sink                 req_chan,
   svpwm_rsp_if.source               rsp_chan,
   input  logic                      csr_we,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [REG_WIDTH-1:0]      csr_wdata
);

   cfg_type                cfg_ff;
   item_type               item_ff;
   item_type               item_in;
   logic                   item_valid_ff;
   logic                   item_valid_in;
   result_type             result_ff;
   result_type             result_in;
   logic                   result_valid_ff;
   logic                   result_valid_in;
   logic                   advance;
   logic                   accept;
   logic                   step;
   logic                   servo_pulse_in;
   logic [ANGLE_WIDTH-1:0] angle_in;
   logic                   drive_forward_in;
   logic                   drive_reverse_in;
   logic [POWER_WIDTH-1:0] power_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.angle1_high_ticks <= 8'd5;
         cfg_ff.angle2_high_ticks <= 8'd10;
         cfg_ff.angle3_high_ticks <= 8'd17;
         cfg_ff.servo_low_ticks <= 8'd156;
         cfg_ff.pwm_slot_ticks <= 8'd78;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_ANGLE1_HIGH: cfg_ff.angle1_high_ticks <= csr_wdata;
            CSR_ANGLE2_HIGH: cfg_ff.angle2_high_ticks <= csr_wdata;
            CSR_ANGLE3_HIGH: cfg_ff.angle3_high_ticks <= csr_wdata;
            CSR_SERVO_LOW:   cfg_ff.servo_low_ticks <= csr_wdata;
            CSR_PWM_SLOT:    cfg_ff.pwm_slot_ticks <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign advance = ~result_valid_ff | rsp_chan.ready;
   assign req_chan.ready = ~reset & (~item_valid_ff | advance);
   assign accept = req_chan.valid & req_chan.ready;
   assign step = item_valid_ff & advance;

   always_comb begin
      item_in = item_ff;
      if (accept) begin
         item_in.tick = req_chan.tick;
         item_in.press_direction = req_chan.press_direction;
         item_in.press_power = req_chan.press_power;
         item_in.press_angle = req_chan.press_angle;
      end
      item_valid_in = accept | (item_valid_ff & ~advance);
   end

   svpwm_servo u_servo (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .item           (item_ff),
      .cfg            (cfg_ff),
      .servo_pulse_in (servo_pulse_in),
      .angle_in       (angle_in)
   );

   svpwm_motor #(
      .PWM_SLOTS (PWM_SLOTS)
   ) u_motor (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .item             (item_ff),
      .cfg              (cfg_ff),
      .drive_forward_in (drive_forward_in),
      .drive_reverse_in (drive_reverse_in),
      .power_in         (power_in)
   );

   always_comb begin
      result_in = result_ff;
      if (step) begin
         result_in.servo_pulse = servo_pulse_in;
         result_in.drive_forward = drive_forward_in;
         result_in.drive_reverse = drive_reverse_in;
         result_in.angle_select = angle_in;
         result_in.power_level = power_in;
      end
      result_valid_in = step | (result_valid_ff & ~rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         result_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         result_valid_ff <= result_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      result_ff <= result_in;
   end

   assign rsp_chan.valid = result_valid_ff;
   assign rsp_chan.servo_pulse = result_ff.servo_pulse;
   assign rsp_chan.drive_forward = result_ff.drive_forward;
   assign rsp_chan.drive_reverse = result_ff.drive_reverse;
   assign rsp_chan.angle_select = result_ff.angle_select;
   assign rsp_chan.power_level = result_ff.power_level;

endmodule

/* sv/svpwm_servo.sv */
module svpwm_servo
   import svpwm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  item_type               item,
   input  cfg_type                cfg,
   output logic                   servo_pulse_in,
   output logic [ANGLE_WIDTH-1:0] angle_in
);

   logic                   phase_ff;
   logic [REG_WIDTH-1:0]   remaining_ff;
   logic [ANGLE_WIDTH-1:0] angle_ff;
   logic                   phase_in;
   logic [REG_WIDTH-1:0]   remaining_in;
   logic [REG_WIDTH-1:0]   high_ticks;

   always_comb begin
      angle_in = angle_ff;
      if (item.press_angle) begin
         angle_in = (angle_ff == ANGLE_THREE) ? ANGLE_ONE : angle_ff + ANGLE_ONE;
      end
   end

   always_comb begin
      case (angle_in)
         ANGLE_ONE: high_ticks = at_least_one(cfg.angle1_high_ticks);
         ANGLE_TWO: high_ticks = at_least_one(cfg.angle2_high_ticks);
         default:   high_ticks = at_least_one(cfg.angle3_high_ticks);
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      remaining_in = remaining_ff;
      if (item.tick) begin
         if (remaining_ff > REG_WIDTH'(1)) begin
            remaining_in = remaining_ff - REG_WIDTH'(1);
         end else if (!phase_ff) begin
            phase_in = 1'b1;
            remaining_in = high_ticks;
         end else begin
            phase_in = 1'b0;
            remaining_in = at_least_one(cfg.servo_low_ticks);
         end
      end
   end

   assign servo_pulse_in = phase_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         remaining_ff <= '0;
         angle_ff <= ANGLE_ONE;
      end else if (step) begin
         phase_ff <= phase_in;
         remaining_ff <= remaining_in;
         angle_ff <= angle_in;
      end
   end

endmodule

/* sv/svpwm_motor.sv */
module svpwm_motor
   import svpwm_pkg::*;
#(
   parameter int unsigned PWM_SLOTS = 10
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  item_type               item,
   input  cfg_type                cfg,
   output logic                   drive_forward_in,
   output logic                   drive_reverse_in,
   output logic [POWER_WIDTH-1:0] power_in
);

   localparam logic [POWER_WIDTH-1:0] SLOTS = POWER_WIDTH'(PWM_SLOTS);

   logic                   direction_ff;
   logic [POWER_WIDTH-1:0] power_ff;
   logic [REG_WIDTH-1:0]   count_ff;
   logic [POWER_WIDTH-1:0] slot_ff;
   logic [POWER_WIDTH-1:0] latched_power_ff;
   logic                   latched_direction_ff;
   logic                   direction_in;
   logic [REG_WIDTH-1:0]   count_in;
   logic [POWER_WIDTH-1:0] slot_in;
   logic [POWER_WIDTH-1:0] latched_power_in;
   logic                   latched_direction_in;
   logic [REG_WIDTH-1:0]   count_next;
   logic [POWER_WIDTH-1:0] slot_next;
   logic                   drive_on;

   always_comb begin
      direction_in = direction_ff ^ item.press_direction;
      power_in = power_ff;
      if (item.press_power) begin
         power_in = (power_ff >= SLOTS) ? '0 : power_ff + POWER_WIDTH'(1);
      end
   end

   always_comb begin
      count_next = count_ff + REG_WIDTH'(1);
      slot_next = slot_ff + POWER_WIDTH'(1);
      count_in = count_ff;
      slot_in = slot_ff;
      latched_power_in = latched_power_ff;
      latched_direction_in = latched_direction_ff;
      if (item.tick) begin
         if (count_next >= at_least_one(cfg.pwm_slot_ticks)) begin
            count_in = '0;
            slot_in = slot_next;
            if (slot_next >= SLOTS) begin
               slot_in = '0;
               latched_power_in = power_in;
               latched_direction_in = direction_in;
            end
         end else begin
            count_in = count_next;
         end
      end
   end

   assign drive_on = slot_in < latched_power_in;
   assign drive_forward_in = drive_on & latched_direction_in;
   assign drive_reverse_in = drive_on & ~latched_direction_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= 1'b0;
         power_ff <= POWER_RESET;
         count_ff <= '0;
         slot_ff <= '0;
         latched_power_ff <= POWER_RESET;
         latched_direction_ff <= 1'b0;
      end else if (step) begin
         direction_ff <= direction_in;
         power_ff <= power_in;
         count_ff <= count_in;
         slot_ff <= slot_in;
         latched_power_ff <= latched_power_in;
         latched_direction_ff <= latched_direction_in;
      end
   end

endmodule

/* sv/svpwm_checker.sv */
module svpwm_checker
   import svpwm_pkg::*;
#(
   parameter int unsigned PWM_SLOTS = 10
)
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   servo_pulse,
   input logic                   drive_forward,
   input logic                   drive_reverse,
   input logic [ANGLE_WIDTH-1:0] angle_select,
   input logic [POWER_WIDTH-1:0] power_level
);

   localparam logic [POWER_WIDTH-1:0] SLOTS = POWER_WIDTH'(PWM_SLOTS);

   // The motor is never driven in both directions at once.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(drive_forward && drive_reverse))
      else $error("both motor lines driven");

   // Angle and power stay within their legal ranges.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (angle_select != '0) && (power_level <= SLOTS))
      else $error("angle or power out of range");

   // After an item is accepted, the response side shows a valid result.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> ##1 rsp_valid)
      else $error("item accepted without a result");

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(servo_pulse)
         && $stable(drive_forward) && $stable(drive_reverse)
         && $stable(angle_select) && $stable(power_level))
      else $error("stalled result changed");

endmodule

bind servo_and_dc_motor_pwm_drive_top svpwm_checker #(
   .PWM_SLOTS (PWM_SLOTS)
) u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .servo_pulse   (rsp_chan.servo_pulse),
   .drive_forward (rsp_chan.drive_forward),
   .drive_reverse (rsp_chan.drive_reverse),
   .angle_select  (rsp_chan.angle_select),
   .power_level   (rsp_chan.power_level)
);
